[sv/imgdc_pkg.sv]
// ============================================================================
// imgdc_pkg
// Shared types and constants for the motion gesture debounce classifier.
// ============================================================================
`default_nettype none

package imgdc_pkg;

  localparam int unsigned AccelW   = 16;
  localparam int unsigned RotW     = 16;
  localparam int unsigned AngleW   = 12;
  localparam int unsigned TiltW    = 11;
  localparam int unsigned TimeW    = 63;
  localparam int unsigned HoldW    = 11;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CoolUsW  = 26;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 3;

  localparam logic [AngleW:0]  DiagRollDdeg   = 13'd750;
  localparam logic [AngleW:0]  SleepyRollDdeg = 13'd1500;
  localparam logic [CountW-1:0] ConfirmCount  = 8'd3;
  localparam logic [HoldW-1:0] HoldShortMs    = 11'd1400;
  localparam logic [HoldW-1:0] HoldLongMs     = 11'd1800;
  localparam logic [CoolUsW-1:0] UsPerMs      = 26'd1000;

  localparam logic [AccelW-1:0]  FreefallReset = 16'd300;
  localparam logic [AccelW-1:0]  ImpactReset   = 16'd2500;
  localparam logic [AccelW-1:0]  PressReset    = 16'd1800;
  localparam logic [RotW-1:0]    ShakeReset    = 16'd2000;
  localparam logic [TiltW-1:0]   TiltReset     = 11'd300;
  localparam logic [CoolUsW-1:0] CoolUsReset   = 26'd3000000;

  typedef enum logic [3:0] {
    GEST_STEADY     = 4'd0,
    GEST_LEFT       = 4'd1,
    GEST_RIGHT      = 4'd2,
    GEST_UP         = 4'd3,
    GEST_DOWN       = 4'd4,
    GEST_UP_LEFT    = 4'd5,
    GEST_UP_RIGHT   = 4'd6,
    GEST_DOWN_LEFT  = 4'd7,
    GEST_DOWN_RIGHT = 4'd8,
    GEST_SHAKE      = 4'd9,
    GEST_SURPRISED  = 4'd10,
    GEST_SLEEPY     = 4'd11,
    GEST_NONE       = 4'd12
  } gesture_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_EMOTION = 2'd2
  } kind_e;

  typedef enum logic {
    OP_SAMPLE     = 1'b0,
    OP_COMPLETION = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FREEFALL = 3'd0,
    REG_IMPACT   = 3'd1,
    REG_PRESS    = 3'd2,
    REG_SHAKE    = 3'd3,
    REG_TILT     = 3'd4,
    REG_COOLDOWN = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [AccelW-1:0]  freefall_limit_mg;
    logic [AccelW-1:0]  impact_limit_mg;
    logic [AccelW-1:0]  press_limit_mg;
    logic [RotW-1:0]    shake_limit_ddps;
    logic [TiltW-1:0]   tilt_limit_ddeg;
    logic [CoolUsW-1:0] cooldown_us;
  } cfg_t;

  typedef struct packed {
    opcode_e              opcode;
    logic [AccelW-1:0]    accel_magnitude_mg;
    logic [RotW-1:0]      rotation_magnitude_ddps;
    logic signed [AngleW-1:0] roll_ddeg;
    logic signed [AngleW-1:0] pitch_ddeg;
    logic                 may_animate;
    logic                 display_busy;
    logic                 was_accepted;
    logic [TimeW-1:0]     time_us;
  } item_t;

  typedef struct packed {
    kind_e            decision_kind;
    logic             emotion_valid;
    logic [3:0]       emotion_code;
    logic [HoldW-1:0] hold_ms;
    logic [3:0]       current_gesture;
  } result_t;

endpackage

`default_nettype wire

[sv/imgdc_cfg.sv]
// ============================================================================
// imgdc_cfg
// Threshold and cooldown registers; the cooldown is kept in microseconds.
// ============================================================================
`default_nettype none

module imgdc_cfg (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [imgdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [imgdc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output imgdc_pkg::cfg_t               cfg_o
);
  import imgdc_pkg::*;

  cfg_t cfg_q;
  logic [CoolUsW-1:0] cool_us;

  assign cool_us = CoolUsW'({10'd0, cfg_wdata_i} * UsPerMs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.freefall_limit_mg <= FreefallReset;
      cfg_q.impact_limit_mg   <= ImpactReset;
      cfg_q.press_limit_mg    <= PressReset;
      cfg_q.shake_limit_ddps  <= ShakeReset;
      cfg_q.tilt_limit_ddeg   <= TiltReset;
      cfg_q.cooldown_us       <= CoolUsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FREEFALL: cfg_q.freefall_limit_mg <= cfg_wdata_i;
        REG_IMPACT:   cfg_q.impact_limit_mg   <= cfg_wdata_i;
        REG_PRESS:    cfg_q.press_limit_mg    <= cfg_wdata_i;
        REG_SHAKE:    cfg_q.shake_limit_ddps  <= cfg_wdata_i;
        REG_TILT:     cfg_q.tilt_limit_ddeg   <= cfg_wdata_i[TiltW-1:0];
        REG_COOLDOWN: cfg_q.cooldown_us       <= cool_us;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/imgdc_classify.sv]
// ============================================================================
// imgdc_classify
// Priority-ordered threshold tests that sort one motion sample into a gesture.
// ============================================================================
`default_nettype none

module imgdc_classify (
  input  wire [imgdc_pkg::AccelW-1:0]        accel_i,
  input  wire [imgdc_pkg::RotW-1:0]          rot_i,
  input  wire signed [imgdc_pkg::AngleW-1:0] roll_i,
  input  wire signed [imgdc_pkg::AngleW-1:0] pitch_i,
  input  imgdc_pkg::cfg_t                    cfg_i,
  output imgdc_pkg::gesture_e                gesture_o
);
  import imgdc_pkg::*;

  logic [AngleW:0] abs_roll;
  logic [AngleW:0] abs_pitch;
  logic [AngleW:0] tilt;
  logic            diag;
  logic            roll_neg;

  assign roll_neg  = roll_i[AngleW-1];
  assign abs_roll  = roll_neg ? (AngleW+1)'(-{roll_i[AngleW-1], roll_i})
                              : {1'b0, roll_i};
  assign abs_pitch = pitch_i[AngleW-1] ? (AngleW+1)'(-{pitch_i[AngleW-1], pitch_i})
                                       : {1'b0, pitch_i};
  assign tilt      = (AngleW+1)'(cfg_i.tilt_limit_ddeg);
  assign diag      = (abs_roll > tilt) && (abs_roll < DiagRollDdeg);

  always_comb begin
    if (accel_i < cfg_i.freefall_limit_mg || accel_i > cfg_i.impact_limit_mg ||
        accel_i > cfg_i.press_limit_mg) begin
      gesture_o = GEST_SURPRISED;
    end else if (rot_i > cfg_i.shake_limit_ddps) begin
      gesture_o = GEST_SHAKE;
    end else if (abs_pitch > tilt) begin
      if (!pitch_i[AngleW-1] && pitch_i != '0) begin
        gesture_o = !diag ? GEST_UP : (roll_neg ? GEST_UP_LEFT : GEST_UP_RIGHT);
      end else begin
        gesture_o = !diag ? GEST_DOWN : (roll_neg ? GEST_DOWN_LEFT : GEST_DOWN_RIGHT);
      end
    end else if (abs_roll > SleepyRollDdeg) begin
      gesture_o = GEST_SLEEPY;
    end else if (abs_roll > tilt) begin
      gesture_o = roll_neg ? GEST_LEFT : GEST_RIGHT;
    end else begin
      gesture_o = GEST_STEADY;
    end
  end

endmodule

`default_nettype wire

[sv/imgdc_decide.sv]
// ============================================================================
// imgdc_decide
// Debounce state, cooldown timing and the press or emotion decision.
// ============================================================================
`default_nettype none

module imgdc_decide (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 advance_i,
  input  imgdc_pkg::item_t    item_i,
  input  imgdc_pkg::gesture_e gesture_i,
  input  imgdc_pkg::cfg_t     cfg_i,
  output imgdc_pkg::result_t  result_o
);
  import imgdc_pkg::*;

  gesture_e               cand_q, cand_d;
  logic [CountW-1:0]      count_q, count_d;
  logic [TimeW-1:0]       last_q, last_d;
  gesture_e               latest_q, latest_d;

  logic [TimeW:0]         elapsed;
  logic                   cooled;
  logic [CountW-1:0]      next_count;
  logic                   confirmed;
  logic                   press_hit;

  assign elapsed = {1'b0, item_i.time_us} - {1'b0, last_q};
  assign cooled  = !elapsed[TimeW] && (elapsed[TimeW-1:0] >= TimeW'(cfg_i.cooldown_us));

  assign next_count = (gesture_i == cand_q)
                    ? ((count_q == '1) ? count_q : count_q + 1'b1)
                    : CountW'(1);
  assign confirmed  = next_count >= ConfirmCount;
  assign press_hit  = item_i.accel_magnitude_mg > cfg_i.press_limit_mg;

  always_comb begin
    cand_d   = cand_q;
    count_d  = count_q;
    last_d   = last_q;
    latest_d = latest_q;
    result_o = '0;
    if (item_i.opcode == OP_COMPLETION) begin
      if (item_i.was_accepted) begin
        last_d = item_i.time_us;
      end
      cand_d  = GEST_NONE;
      count_d = '0;
    end else begin
      latest_d = gesture_i;
      if (!item_i.may_animate || gesture_i == GEST_STEADY) begin
        cand_d  = GEST_NONE;
        count_d = '0;
      end else begin
        cand_d  = gesture_i;
        count_d = next_count;
        if (press_hit && !item_i.display_busy && cooled) begin
          result_o.decision_kind = KIND_PRESS;
          result_o.hold_ms       = HoldShortMs;
          if (confirmed) begin
            result_o.emotion_valid = 1'b1;
            result_o.emotion_code  = gesture_i;
          end
        end else if (confirmed && !item_i.display_busy && cooled) begin
          result_o.decision_kind = KIND_EMOTION;
          result_o.emotion_valid = 1'b1;
          result_o.emotion_code  = gesture_i;
          result_o.hold_ms = (gesture_i == GEST_SHAKE || gesture_i == GEST_SURPRISED)
                           ? HoldShortMs : HoldLongMs;
        end
      end
    end
    result_o.current_gesture = latest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q   <= GEST_NONE;
      count_q  <= '0;
      last_q   <= '0;
      latest_q <= GEST_STEADY;
    end else if (advance_i) begin
      cand_q   <= cand_d;
      count_q  <= count_d;
      last_q   <= last_d;
      latest_q <= latest_d;
    end
  end

endmodule

`default_nettype wire

[sv/imu_gesture_debounce_classifier.sv]
// An accepted item is held in the input register and then loaded into the
// result register, from which its result transfers to the output.
// Throughput: one item per cycle unless the output stalls; the input register
// hands over to the result register whenever that one is empty or being taken.
// Reset: asynchronous, active low; it restores the default thresholds, clears
// the candidate, the repeat count, the last accepted timestamp and both stages.
// ============================================================================
// imu_gesture_debounce_classifier
// Motion gesture classifier with three-sample debounce and cooldown control.
// ============================================================================
`default_nettype none

module imu_gesture_debounce_classifier (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [imgdc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [imgdc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // accel_magnitude_mg, rotation_magnitude_ddps, roll_ddeg, pitch_ddeg,
  // may_animate, display_busy, was_accepted, time_us, zero padding
  input  wire [imgdc_pkg::InDataW-1:0]   s_axis_tdata,
  // opcode
  input  wire [imgdc_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // emotion_code, hold_ms, current_gesture, zero padding
  output logic [imgdc_pkg::OutDataW-1:0] m_axis_tdata,
  // decision_kind, emotion_valid
  output logic [imgdc_pkg::OutUserW-1:0] m_axis_tuser
);
  import imgdc_pkg::*;

  cfg_t     cfg;
  item_t    item_q, item_d;
  logic     in_valid_q;
  logic     out_valid_q;
  result_t  res_q, res_d;
  gesture_e gesture;
  logic     advance;
  logic     take_in;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  assign item_d.opcode                  = opcode_e'(s_axis_tuser[0]);
  assign item_d.accel_magnitude_mg      = s_axis_tdata[15:0];
  assign item_d.rotation_magnitude_ddps = s_axis_tdata[31:16];
  assign item_d.roll_ddeg               = s_axis_tdata[43:32];
  assign item_d.pitch_ddeg              = s_axis_tdata[55:44];
  assign item_d.may_animate             = s_axis_tdata[56];
  assign item_d.display_busy            = s_axis_tdata[57];
  assign item_d.was_accepted            = s_axis_tdata[58];
  assign item_d.time_us                 = s_axis_tdata[121:59];

  imgdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  imgdc_classify u_classify (
    .accel_i   (item_q.accel_magnitude_mg),
    .rot_i     (item_q.rotation_magnitude_ddps),
    .roll_i    (item_q.roll_ddeg),
    .pitch_i   (item_q.pitch_ddeg),
    .cfg_i     (cfg),
    .gesture_o (gesture)
  );

  imgdc_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .gesture_i (gesture),
    .cfg_i     (cfg),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, res_q.current_gesture, res_q.hold_ms, res_q.emotion_code};
  assign m_axis_tuser  = {res_q.emotion_valid, res_q.decision_kind};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] != KIND_NONE)
    else $error("emotion flagged without a decision");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == KIND_NONE |-> res_q.hold_ms == '0)
    else $error("hold time set without a decision");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled while the pipeline could move");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("advanced item did not reach the result register");

endmodule

`default_nettype wire
